[hw/rtl/wmf_pkg.sv]
// Shared types and constants of the window median filter.
package wmf_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int MAX_HALF = 3;
  localparam int PIXEL_BITS = 16;

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int ROW_BITS = 16;
  localparam int WIDTH_BITS = COL_BITS + 1;
  localparam int HALF_BITS = 2;
  localparam int WIN = 2 * MAX_HALF + 1;
  localparam int WIN_CELLS = WIN * WIN;
  localparam int CNT_BITS = $clog2(WIN_CELLS + 1);
  localparam int LANE_BITS = $clog2(2 * MAX_HALF + 2);
  localparam int RING_ROWS = 1 << LANE_BITS;
  localparam int SR_LEN = MAX_HALF + WIN;
  localparam int SR_IDX_BITS = $clog2(SR_LEN + MAX_HALF + 1);
  localparam int LEAD_BITS = $clog2(MAX_HALF + 2);
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HALF_WIDTH = 2'd2;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  localparam int OUT_BITS = PIXEL_BITS + 1 + ROW_BITS + COL_BITS;
  localparam int OUT_BYTES_BITS = ((OUT_BITS + 7) / 8) * 8;

  typedef logic signed [PIXEL_BITS:0] median_t;
  typedef logic [WIN_CELLS-1:0][PIXEL_BITS-1:0] win_vals_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic last;
  } pos_t;

  typedef struct packed {
    logic vld;
    logic [CNT_BITS-1:0] count;
    pos_t pos;
  } win_meta_t;

endpackage

[hw/rtl/wmf_median.sv]
// Rank-based median selection over one window, three register stages.
module wmf_median (
  input  logic                clk,
  input  logic                rst,
  input  wmf_pkg::win_vals_t  vals,
  input  logic [wmf_pkg::WIN_CELLS-1:0] mask,
  input  wmf_pkg::win_meta_t  meta,
  output wmf_pkg::median_t    median,
  output wmf_pkg::win_meta_t  res_meta
);
  import wmf_pkg::*;

  logic [WIN_CELLS-1:0][WIN_CELLS-1:0] lt_cmp;
  logic [WIN_CELLS-1:0][WIN_CELLS-1:0] lt1;
  win_vals_t vals1;
  logic [WIN_CELLS-1:0] mask1;
  win_meta_t meta1;

  logic [WIN_CELLS-1:0][CNT_BITS-1:0] rank_sum;
  logic [WIN_CELLS-1:0][CNT_BITS-1:0] rank2;
  win_vals_t vals2;
  logic [WIN_CELLS-1:0] mask2;
  win_meta_t meta2;

  logic [CNT_BITS-1:0] k_lo;
  logic [CNT_BITS-1:0] k_hi;
  logic [PIXEL_BITS-1:0] v_lo;
  logic [PIXEL_BITS-1:0] v_hi;

  always_comb begin
    for (int i = 0; i < WIN_CELLS; i++) begin
      for (int j = 0; j < WIN_CELLS; j++) begin
        lt_cmp[i][j] = mask[j] &&
          (($signed(vals[j]) < $signed(vals[i])) || ((vals[j] == vals[i]) && (j < i)));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < WIN_CELLS; i++) begin
      rank_sum[i] = '0;
      for (int j = 0; j < WIN_CELLS; j++) begin
        rank_sum[i] = rank_sum[i] + CNT_BITS'(lt1[i][j]);
      end
    end
  end

  always_comb begin
    k_lo = (meta2.count - CNT_BITS'(1)) >> 1;
    k_hi = meta2.count >> 1;
    v_lo = '0;
    v_hi = '0;
    for (int i = 0; i < WIN_CELLS; i++) begin
      if (mask2[i] && rank2[i] == k_lo) begin
        v_lo = v_lo | vals2[i];
      end
      if (mask2[i] && rank2[i] == k_hi) begin
        v_hi = v_hi | vals2[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    lt1 <= lt_cmp;
    vals1 <= vals;
    mask1 <= mask;
    rank2 <= rank_sum;
    vals2 <= vals1;
    mask2 <= mask1;
    median <= $signed({v_lo[PIXEL_BITS-1], v_lo}) + $signed({v_hi[PIXEL_BITS-1], v_hi});
    if (rst) begin
      meta1 <= '0;
      meta2 <= '0;
      res_meta <= '0;
    end else begin
      meta1 <= meta;
      meta2 <= meta1;
      res_meta <= meta2;
    end
  end

endmodule

[hw/rtl/window_median_filter_unit.sv]
// Streaming square-window median filter with a banked line store.
// Outputs pass the b_, c_ and median registers and the result buffer; the line store
// has one column read port. One pixel or drain beat per cycle is taken unless stalled.
// Up to eight results are buffered; input stalls only when that buffer is committed.
// Reset is synchronous and sets the registers to width 4096, height 1, half width 1.
module window_median_filter_unit (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [15:0] s_tdata,  // [15:0] pixel
  input  logic s_tuser,         // [0] kind
  output logic m_tvalid,
  input  logic m_tready,
  output logic [47:0] m_tdata,  // [16:0] median_doubled, [32:17] out_row, [44:33] out_col
  output logic m_tlast,
  input  logic cfg_we,
  input  logic [wmf_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [wmf_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import wmf_pkg::*;

  logic [WIDTH_BITS-1:0] cfg_width;
  logic [ROW_BITS-1:0] cfg_height;
  logic [HALF_BITS-1:0] cfg_half;

  logic [COL_BITS-1:0] w_last;
  logic [ROW_BITS-1:0] h_last;
  logic [HALF_BITS-1:0] hw;

  logic [ROW_BITS-1:0] in_row, in_row_next;
  logic [COL_BITS-1:0] in_col, in_col_next;
  logic [ROW_BITS-1:0] emit_row;
  logic [COL_BITS-1:0] emit_col;
  logic [ROW_BITS-1:0] fetch_row;
  logic [COL_BITS-1:0] fetch_col;
  logic [LEAD_BITS-1:0] lead;
  logic [LEAD_BITS-1:0] lead_fetch;

  logic step, wen, emit_ok, fetch_ok, restart, emit_last;
  logic [ROW_BITS:0] er_sum, fr_sum;
  logic [COL_BITS:0] ec_sum;
  logic [ROW_BITS-1:0] er_hi, fr_band;
  logic [COL_BITS-1:0] ec_hi, c_lo;
  logic [HALF_BITS-1:0] gap;
  logic [SR_IDX_BITS-1:0] base;
  logic [WIN-1:0] rvalid, cvalid;
  logic [2:0] ccnt, rcnt;
  logic [ROW_BITS+1:0] rr;

  logic [RING_ROWS*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
  logic [RING_ROWS*PIXEL_BITS-1:0] rd_data;

  logic b_fetch, b_fwd;
  logic [LANE_BITS-1:0] b_wlane;
  logic [PIXEL_BITS-1:0] b_wpix;
  logic [SR_IDX_BITS-1:0] b_base;
  logic [WIN-1:0] b_rvalid, b_cvalid;
  win_meta_t b_meta;

  logic [RING_ROWS*PIXEL_BITS-1:0] col_new;
  logic [SR_LEN-1:0][RING_ROWS*PIXEL_BITS-1:0] sr, sr_eff;
  logic [RING_ROWS*PIXEL_BITS-1:0] col_sel;
  logic [SR_IDX_BITS-1:0] sr_idx;
  logic [LANE_BITS-1:0] lane;
  win_vals_t g_vals, c_vals;
  logic [WIN_CELLS-1:0] g_mask, c_mask;
  win_meta_t c_meta;

  median_t res_median;
  win_meta_t res_meta;

  logic [OUT_BITS:0] fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [FIFO_PTR_BITS:0] fifo_count;
  logic [FIFO_PTR_BITS:0] occ;
  logic m_beat;

  function automatic logic passed(input logic [ROW_BITS-1:0] ir, input logic [COL_BITS-1:0] ic,
                                  input logic [ROW_BITS-1:0] r, input logic [COL_BITS-1:0] c);
    return (ir > r) || ((ir == r) && (ic > c));
  endfunction

  always_comb begin
    if (cfg_width == '0) begin
      w_last = '0;
    end else if (cfg_width > WIDTH_BITS'(MAX_WIDTH)) begin
      w_last = COL_BITS'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_BITS'(cfg_width - WIDTH_BITS'(1));
    end
    h_last = (cfg_height == '0) ? '0 : cfg_height - ROW_BITS'(1);
    hw = (32'(cfg_half) > MAX_HALF) ? HALF_BITS'(MAX_HALF) : cfg_half;
  end

  assign step = s_tvalid && s_tready;
  assign wen = step && (s_tuser == KIND_PIXEL) && (in_row <= h_last);
  assign restart = cfg_we && (cfg_index <= REG_HALF_WIDTH);

  always_comb begin
    in_row_next = in_row;
    in_col_next = in_col;
    if (wen) begin
      if (in_col == w_last) begin
        in_col_next = '0;
        in_row_next = in_row + ROW_BITS'(1);
      end else begin
        in_col_next = in_col + COL_BITS'(1);
      end
    end

    er_sum = {1'b0, emit_row} + (ROW_BITS + 1)'(hw);
    er_hi = (er_sum > {1'b0, h_last}) ? h_last : er_sum[ROW_BITS-1:0];
    ec_sum = {1'b0, emit_col} + (COL_BITS + 1)'(hw);
    ec_hi = (ec_sum > {1'b0, w_last}) ? w_last : ec_sum[COL_BITS-1:0];
    fr_sum = {1'b0, fetch_row} + (ROW_BITS + 1)'(hw);
    fr_band = (fr_sum > {1'b0, h_last}) ? h_last : fr_sum[ROW_BITS-1:0];

    emit_ok = step && passed(in_row_next, in_col_next, er_hi, ec_hi);
    fetch_ok = step && (fetch_row <= h_last) && (lead <= LEAD_BITS'(hw)) &&
               passed(in_row_next, in_col_next, fr_band, fetch_col);
    emit_last = (emit_row == h_last) && (emit_col == w_last);

    lead_fetch = lead + LEAD_BITS'(fetch_ok);
    gap = HALF_BITS'(ec_hi - emit_col);
    base = SR_IDX_BITS'(lead_fetch) - SR_IDX_BITS'(1) - SR_IDX_BITS'(gap);

    c_lo = (emit_col > COL_BITS'(hw)) ? emit_col - COL_BITS'(hw) : '0;
    ccnt = 3'(ec_hi - c_lo + COL_BITS'(1));
    rcnt = '0;
    for (int i = 0; i < WIN; i++) begin
      rr = (ROW_BITS + 2)'(emit_row) + (ROW_BITS + 2)'(i) - (ROW_BITS + 2)'(MAX_HALF);
      rvalid[i] = !rr[ROW_BITS+1] && (rr[ROW_BITS:0] <= {1'b0, h_last}) &&
                  (i >= MAX_HALF - int'(hw)) && (i <= MAX_HALF + int'(hw));
      cvalid[i] = (3'(i) < ccnt);
      rcnt = rcnt + 3'(rvalid[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width <= WIDTH_BITS'(MAX_WIDTH);
      cfg_height <= ROW_BITS'(1);
      cfg_half <= HALF_BITS'(1);
      in_row <= '0;
      in_col <= '0;
      emit_row <= '0;
      emit_col <= '0;
      fetch_row <= '0;
      fetch_col <= '0;
      lead <= '0;
    end else if (restart) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: cfg_width <= cfg_data[WIDTH_BITS-1:0];
        REG_IMAGE_HEIGHT: cfg_height <= cfg_data[ROW_BITS-1:0];
        REG_HALF_WIDTH: cfg_half <= cfg_data[HALF_BITS-1:0];
        default: cfg_half <= cfg_half;
      endcase
      in_row <= '0;
      in_col <= '0;
      emit_row <= '0;
      emit_col <= '0;
      fetch_row <= '0;
      fetch_col <= '0;
      lead <= '0;
    end else if (emit_ok && emit_last) begin
      in_row <= '0;
      in_col <= '0;
      emit_row <= '0;
      emit_col <= '0;
      fetch_row <= '0;
      fetch_col <= '0;
      lead <= '0;
    end else begin
      in_row <= in_row_next;
      in_col <= in_col_next;
      lead <= lead_fetch - LEAD_BITS'(emit_ok);
      if (emit_ok) begin
        if (emit_col == w_last) begin
          emit_col <= '0;
          emit_row <= emit_row + ROW_BITS'(1);
        end else begin
          emit_col <= emit_col + COL_BITS'(1);
        end
      end
      if (fetch_ok) begin
        if (fetch_col == w_last) begin
          fetch_col <= '0;
          fetch_row <= fetch_row + ROW_BITS'(1);
        end else begin
          fetch_col <= fetch_col + COL_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      line_mem[in_col][in_row[LANE_BITS-1:0]*PIXEL_BITS +: PIXEL_BITS] <= s_tdata;
    end
    rd_data <= line_mem[fetch_col];
  end

  always_ff @(posedge clk) begin
    b_wlane <= in_row[LANE_BITS-1:0];
    b_wpix <= s_tdata;
    b_base <= base;
    b_rvalid <= rvalid;
    b_cvalid <= cvalid;
    if (rst) begin
      b_fetch <= 1'b0;
      b_fwd <= 1'b0;
      b_meta <= '0;
    end else begin
      b_fetch <= fetch_ok;
      b_fwd <= wen && fetch_ok && (in_col == fetch_col);
      b_meta.vld <= emit_ok;
      b_meta.count <= CNT_BITS'(CNT_BITS'(rcnt) * CNT_BITS'(ccnt));
      b_meta.pos.row <= emit_row;
      b_meta.pos.col <= emit_col;
      b_meta.pos.last <= emit_last;
    end
  end

  always_comb begin
    col_new = rd_data;
    if (b_fwd) begin
      col_new[b_wlane*PIXEL_BITS +: PIXEL_BITS] = b_wpix;
    end
    sr_eff = sr;
    if (b_fetch) begin
      sr_eff[0] = col_new;
      for (int k = 1; k < SR_LEN; k++) begin
        sr_eff[k] = sr[k-1];
      end
    end
    for (int k = 0; k < WIN; k++) begin
      sr_idx = b_base + SR_IDX_BITS'(k);
      col_sel = (sr_idx < SR_IDX_BITS'(SR_LEN)) ? sr_eff[sr_idx] : '0;
      for (int i = 0; i < WIN; i++) begin
        lane = LANE_BITS'(b_meta.pos.row[LANE_BITS-1:0] + LANE_BITS'(i) - LANE_BITS'(MAX_HALF));
        g_vals[i*WIN+k] = col_sel[lane*PIXEL_BITS +: PIXEL_BITS];
        g_mask[i*WIN+k] = b_rvalid[i] && b_cvalid[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_fetch) begin
      sr <= sr_eff;
    end
    c_vals <= g_vals;
    c_mask <= g_mask;
    if (rst) begin
      c_meta <= '0;
    end else begin
      c_meta <= b_meta;
    end
  end

  wmf_median u_median (
    .clk      (clk),
    .rst      (rst),
    .vals     (c_vals),
    .mask     (c_mask),
    .meta     (c_meta),
    .median   (res_median),
    .res_meta (res_meta)
  );

  assign m_beat = m_tvalid && m_tready;
  assign m_tvalid = (fifo_count != '0);
  assign s_tready = (occ < (FIFO_PTR_BITS + 1)'(FIFO_DEPTH));
  assign m_tdata = OUT_BYTES_BITS'(fifo_mem[rd_ptr][OUT_BITS:1]);
  assign m_tlast = fifo_mem[rd_ptr][0];

  always_ff @(posedge clk) begin
    if (res_meta.vld) begin
      fifo_mem[wr_ptr] <= {res_meta.pos.col, res_meta.pos.row, res_median, res_meta.pos.last};
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fifo_count <= '0;
      occ <= '0;
    end else begin
      if (res_meta.vld) begin
        wr_ptr <= wr_ptr + FIFO_PTR_BITS'(1);
      end
      if (m_beat) begin
        rd_ptr <= rd_ptr + FIFO_PTR_BITS'(1);
      end
      fifo_count <= fifo_count + (FIFO_PTR_BITS + 1)'(res_meta.vld) -
                    (FIFO_PTR_BITS + 1)'(m_beat);
      occ <= occ + (FIFO_PTR_BITS + 1)'(emit_ok) - (FIFO_PTR_BITS + 1)'(m_beat);
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= (FIFO_PTR_BITS + 1)'(FIFO_DEPTH))
    else $error("result buffer overcommitted");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_meta.vld |-> fifo_count < (FIFO_PTR_BITS + 1)'(FIFO_DEPTH))
    else $error("result buffer written while full");

  a_window_fetched: assert property (@(posedge clk) disable iff (rst)
    emit_ok |-> lead_fetch > LEAD_BITS'(gap))
    else $error("window emitted before its last column was fetched");

  a_lead_bound: assert property (@(posedge clk) disable iff (rst)
    lead <= LEAD_BITS'(MAX_HALF + 1))
    else $error("column fetch ran too far ahead");

endmodule

[tb/window_median_filter_unit_tb.sv]
// Self-checking testbench of the window median filter: predicted medians against stream output.
module window_median_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wmf_pkg::*;

  typedef struct {
    logic [16:0] median;
    logic [15:0] row;
    logic [11:0] col;
    logic last;
  } median_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic s_tuser = KIND_PIXEL;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  window_median_filter_unit i_dut (.*);

  always #6 clk = ~clk;

  median_beat_t pending_medians[$];
  logic signed [15:0] line_mem [0:8*MAX_WIDTH-1];
  int reg_width = 4096, reg_height = 1, reg_half = 1;
  int in_r, in_c, emit_r, emit_c;
  int errors = 0;
  int pixels_sent = 0;
  bit steady = 1'b0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  function automatic int eff_w();
    return reg_width == 0 ? 1 : (reg_width > MAX_WIDTH ? MAX_WIDTH : reg_width);
  endfunction

  function automatic int eff_h();
    return reg_height == 0 ? 1 : reg_height;
  endfunction

  function automatic bit image_idle();
    return in_r == 0 && in_c == 0 && emit_r == 0 && emit_c == 0;
  endfunction

  task automatic predict_median(input logic kind, input logic signed [15:0] pix);
    int w, h, hw, nr, nc, r0, c0, n, i, j, v, sum;
    int win [0:48];
    median_beat_t e;
    w = eff_w();
    h = eff_h();
    hw = reg_half;
    if (kind == KIND_PIXEL && in_r < h) begin
      line_mem[(in_r % 8) * MAX_WIDTH + in_c] = pix;
      in_c++;
      if (in_c >= w) begin
        in_c = 0;
        in_r++;
      end
    end
    nr = emit_r + hw;
    if (nr > h - 1) nr = h - 1;
    nc = emit_c + hw;
    if (nc > w - 1) nc = w - 1;
    if (!(in_r > nr || (in_r == nr && in_c > nc))) return;
    r0 = emit_r > hw ? emit_r - hw : 0;
    c0 = emit_c > hw ? emit_c - hw : 0;
    n = 0;
    for (int r = r0; r <= nr; r++)
      for (int c = c0; c <= nc; c++) begin
        win[n] = line_mem[(r % 8) * MAX_WIDTH + c];
        n++;
      end
    for (i = 1; i < n; i++) begin
      v = win[i];
      j = i;
      while (j > 0 && win[j-1] > v) begin
        win[j] = win[j-1];
        j--;
      end
      win[j] = v;
    end
    sum = (n % 2) ? win[n/2] * 2 : win[n/2-1] + win[n/2];
    e.median = sum[16:0];
    e.row = emit_r[15:0];
    e.col = emit_c[11:0];
    e.last = (emit_r == h - 1) && (emit_c == w - 1);
    pending_medians.push_back(e);
    if (e.last) begin
      in_r = 0; in_c = 0; emit_r = 0; emit_c = 0;
    end else begin
      emit_c++;
      if (emit_c >= w) begin
        emit_c = 0;
        emit_r++;
      end
    end
  endtask

  task automatic send_beat(input logic kind, input logic [15:0] pix);
    if (!steady && $urandom_range(0, 99) < 19) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= pix;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_median(kind, pix);
    if (kind == KIND_PIXEL) pixels_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) reg_width = value & 16'h1FFF;
    else if (idx == REG_IMAGE_HEIGHT) reg_height = value & 16'hFFFF;
    else reg_half = value & 3;
    in_r = 0; in_c = 0; emit_r = 0; emit_c = 0;
  endtask

  task automatic set_image(input int w, input int h, input int hw);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_HALF_WIDTH, hw);
  endtask

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 3));
      3: return 16'hFFFF - 16'($urandom_range(0, 2));
      default: return 16'($urandom);
    endcase
  endfunction

  // Sends one whole image, then drain beats (some of them late pixels) until it is flushed.
  task automatic run_image();
    int total;
    total = eff_w() * eff_h();
    for (int k = 0; k < total; k++) send_beat(KIND_PIXEL, pick_pixel());
    while (!image_idle())
      send_beat($urandom_range(0, 3) == 0 ? KIND_PIXEL : KIND_DRAIN, pick_pixel());
  endtask

  // Sends the first pixels of a large image; the next register write restarts it.
  task automatic run_pixels(input int count);
    for (int k = 0; k < count; k++) send_beat(KIND_PIXEL, pick_pixel());
  endtask

  task automatic test_idle_drain();
    send_beat(KIND_DRAIN, 16'h0000);
    send_beat(KIND_DRAIN, 16'hFFFF);
  endtask

  task automatic test_directed();
    set_image(3, 3, 1);
    run_image();
    set_image(1, 1, 0);
    run_image();
    set_image(0, 0, 2);
    run_image();
    set_image(2, 5, 3);
    run_image();
    set_image(4, 4, 3);
    run_image();
  endtask

  task automatic test_widest();
    set_image(8191, 1, 3);
    run_pixels(150);
    set_image(4096, 2, 0);
    run_pixels(150);
  endtask

  task automatic test_tallest();
    steady = 1'b1;
    set_image(1, 65535, 0);
    run_pixels(300);
    steady = 1'b0;
  endtask

  task automatic test_backpressure();
    set_image(10, 6, 2);
    hold_off = 1'b1;
    run_image();
    hold_off = 1'b0;
  endtask

  task automatic test_random();
    int start;
    start = pixels_sent;
    while (pixels_sent - start < 800) begin
      set_image($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 3));
      steady = ($urandom_range(0, 9) == 0);
      run_image();
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_off) m_tready <= 1'b0;
    else m_tready <= steady || $urandom_range(0, 99) >= 19;
  end

  // Releases the long receiver hold-off after it has been raised.
  initial begin
    wait (hold_off);
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    median_beat_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_medians.size() == 0) begin
        report_mismatch("unexpected beat row", m_tdata[32:17], -1);
      end else begin
        e = pending_medians.pop_front();
        if (m_tdata[16:0] !== e.median)
          report_mismatch("median_doubled", $signed(m_tdata[16:0]), $signed(e.median));
        if (m_tdata[32:17] !== e.row) report_mismatch("out_row", m_tdata[32:17], e.row);
        if (m_tdata[44:33] !== e.col) report_mismatch("out_col", m_tdata[44:33], e.col);
        if (m_tlast !== e.last) report_mismatch("frame_last", m_tlast, e.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 3000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    in_r = 0; in_c = 0; emit_r = 0; emit_c = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_drain();
    test_directed();
    test_widest();
    test_backpressure();
    test_random();
    test_tallest();
    settle();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
